/* rtl/iomm_pkg.sv */
// Shared types, constants and the I/O write-mask table of the masked memory.
// Used by iomm_ctrl, iomm_datapath and io_masked_memory_with_dma.
`timescale 1ns / 1ps

package iomm_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int DMA_LENGTH_DEFAULT = 160;

    // access kinds; the unused code is handled as a read
    localparam logic [1:0] KIND_READ     = 2'd0;
    localparam logic [1:0] KIND_ORDINARY = 2'd1;
    localparam logic [1:0] KIND_INIT     = 2'd2;

    localparam logic [ADDR_W-1:0] SERIAL_DATA = 16'hFF01;
    localparam logic [ADDR_W-1:0] SERIAL_CTRL = 16'hFF02;
    localparam logic [ADDR_W-1:0] TIMER_DIV   = 16'hFF04;
    localparam logic [ADDR_W-1:0] LCD_LINE    = 16'hFF44;
    localparam logic [ADDR_W-1:0] DMA_REG     = 16'hFF46;
    localparam logic [ADDR_W-1:0] DMA_TARGET  = 16'hFE00;
    localparam logic [DATA_W-1:0] SERIAL_GO   = 8'h81;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] keep;
        logic [DATA_W-1:0] take;
    } mask_rule_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
        logic merge;
        logic dma;
        logic respond;
    } iomm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic dma_last;
        logic is_rmw;
        logic is_dma;
    } iomm_status_t;

    function automatic mask_rule_t mask_rule(input logic [ADDR_W-1:0] addr);
        mask_rule_t r;
        r.hit = 1'b1;
        unique case (addr)
            16'hFF00: begin r.keep = 8'hCF; r.take = 8'h30; end
            16'hFF02: begin r.keep = 8'h7C; r.take = 8'h83; end
            16'hFF07: begin r.keep = 8'hF8; r.take = 8'h07; end
            16'hFF0F: begin r.keep = 8'hE0; r.take = 8'h1F; end
            16'hFF10: begin r.keep = 8'h80; r.take = 8'h7F; end
            16'hFF1A: begin r.keep = 8'h7F; r.take = 8'h80; end
            16'hFF1C: begin r.keep = 8'h9F; r.take = 8'h60; end
            16'hFF21: begin r.keep = 8'hC0; r.take = 8'h3F; end
            16'hFF23: begin r.keep = 8'h3F; r.take = 8'hC0; end
            16'hFF26: begin r.keep = 8'h7F; r.take = 8'h80; end
            16'hFF41: begin r.keep = 8'h87; r.take = 8'h78; end
            16'hFFFF: begin r.keep = 8'hE0; r.take = 8'h1F; end
            default:
            begin
                r.hit  = 1'b0;
                r.keep = '0;
                r.take = '0;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/iomm_ctrl.sv */
// Sequencing state machine of the masked memory: clearing pass, access
// steps, DMA stream. Depends on iomm_pkg.
`timescale 1ns / 1ps

module iomm_ctrl
    import iomm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  iomm_status_t status,
    output iomm_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_MERGE = 6'b001000,
        ST_DMA   = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (status.is_rmw)
                begin
                    state_next = ST_MERGE;
                end
                else if (status.is_dma)
                begin
                    state_next = ST_DMA;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = ST_RESP;
            end
            ST_DMA:
            begin
                cmd.dma = 1'b1;
                if (status.dma_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* rtl/iomm_datapath.sv */
// Datapath of the masked memory: 64 KiB byte array, latched transaction,
// write-mask merge, DMA and clear counters, result registers. Depends on iomm_pkg.
`timescale 1ns / 1ps

module iomm_datapath
    import iomm_pkg::*;
#(
    parameter int DMA_LENGTH = DMA_LENGTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  iomm_cmd_t         cmd,
    output iomm_status_t      status,
    input  logic [1:0]        kind,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] data,
    output logic              done,
    output logic [DATA_W-1:0] read_data,
    output logic              serial_valid,
    output logic [DATA_W-1:0] serial_byte
);

    localparam int CNT_W = $clog2(DMA_LENGTH + 1);
    localparam logic [CNT_W-1:0] DMA_LAST_CNT = CNT_W'(DMA_LENGTH);

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [1:0]        kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic [CNT_W-1:0]  dma_cnt_reg;
    logic [CNT_W-1:0]  dma_cnt_next;

    logic              done_reg;
    logic              done_next;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;
    logic              serial_valid_reg;
    logic              serial_valid_next;
    logic [DATA_W-1:0] serial_byte_reg;
    logic [DATA_W-1:0] serial_byte_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;

    logic       is_write;
    logic       is_ordinary;
    logic       is_serial;
    logic       is_clear_reg;
    mask_rule_t rule;

    // decode of the latched transaction
    always_comb
    begin
        rule         = mask_rule(addr_reg);
        is_write     = (kind_reg == KIND_ORDINARY) || (kind_reg == KIND_INIT);
        is_ordinary  = (kind_reg == KIND_ORDINARY);
        is_serial    = is_write && (addr_reg == SERIAL_CTRL) && (data_reg == SERIAL_GO);
        is_clear_reg = (addr_reg == TIMER_DIV) || (addr_reg == LCD_LINE);
    end

    assign status.clr_last = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));
    assign status.dma_last = (dma_cnt_reg == DMA_LAST_CNT);
    assign status.is_rmw   = is_ordinary && rule.hit && !is_serial;
    assign status.is_dma   = is_ordinary && (addr_reg == DMA_REG);

    always_comb
    begin
        we           = 1'b0;
        waddr        = addr_reg;
        wdata        = data_reg;
        raddr        = addr_reg;
        clr_cnt_next = clr_cnt_reg;
        dma_cnt_next = dma_cnt_reg;
        if (cmd.clear)
        begin
            we           = 1'b1;
            waddr        = clr_cnt_reg;
            wdata        = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.exec)
        begin
            dma_cnt_next = '0;
            // serial go: control register ends cleared, data register read out
            priority if (is_serial)
            begin
                we    = 1'b1;
                waddr = SERIAL_CTRL;
                wdata = '0;
                raddr = SERIAL_DATA;
            end
            else if (!is_write || status.is_rmw || status.is_dma)
            begin
                we = 1'b0;
            end
            else
            begin
                we    = 1'b1;
                wdata = (is_ordinary && is_clear_reg) ? '0 : data_reg;
            end
        end
        if (cmd.merge)
        begin
            we    = 1'b1;
            wdata = (rdata_reg & rule.keep) | (data_reg & rule.take);
        end
        if (cmd.dma)
        begin
            // read runs one step ahead of the write
            raddr        = {data_reg, 8'h00} + ADDR_W'(dma_cnt_reg);
            we           = (dma_cnt_reg != '0);
            waddr        = DMA_TARGET + ADDR_W'(dma_cnt_reg) - 1'b1;
            wdata        = rdata_reg;
            dma_cnt_next = dma_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            data_reg <= data;
        end
    end

    always_comb
    begin
        done_next         = cmd.respond;
        read_data_next    = read_data_reg;
        serial_valid_next = serial_valid_reg;
        serial_byte_next  = serial_byte_reg;
        if (cmd.respond)
        begin
            read_data_next    = is_write ? '0 : rdata_reg;
            serial_valid_next = is_serial;
            serial_byte_next  = is_serial ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            dma_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            dma_cnt_reg <= dma_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg    <= read_data_next;
        serial_valid_reg <= serial_valid_next;
        serial_byte_reg  <= serial_byte_next;
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign serial_valid = serial_valid_reg;
    assign serial_byte  = serial_byte_reg;

endmodule

/* rtl/io_masked_memory_with_dma.sv */
// Masked 64 KiB byte memory with sprite-table DMA and serial output; top level.
// Depends on iomm_pkg, iomm_ctrl and iomm_datapath.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy low; its single result
// appears for one cycle with done high and cannot be stalled, so the receiver
// must capture it then. After reset the memory is zeroed by a clearing pass,
// one byte per cycle, with busy high. A read, a raw write or a cleared
// register runs through the execute and respond states, a masked I/O write
// adds a merge state between them (read-modify-write on the single memory),
// and a DMA write a DMA state that first primes the read and then copies
// DMA_LENGTH bytes, one byte per cycle through the memory's read and write
// ports. The result shows in the cycle after the last busy cycle.

module io_masked_memory_with_dma
    import iomm_pkg::*;
#(
    parameter int DMA_LENGTH = DMA_LENGTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] data,
    output logic              busy,
    output logic              done,
    output logic [DATA_W-1:0] read_data,
    output logic              serial_valid,
    output logic [DATA_W-1:0] serial_byte
);

    iomm_cmd_t    cmd;
    iomm_status_t status;

    iomm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    iomm_datapath #(
        .DMA_LENGTH (DMA_LENGTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .address      (address),
        .data         (data),
        .done         (done),
        .read_data    (read_data),
        .serial_valid (serial_valid),
        .serial_byte  (serial_byte)
    );

endmodule

/* bench/io_masked_memory_with_dma_test.sv */
// Self-checking bench for io_masked_memory_with_dma: directed and random accesses.
// Needs iomm_pkg and the RTL of the block; the expected bytes come from a local memory image.
`timescale 1ns / 1ps

module io_masked_memory_with_dma_test;
    import iomm_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;    // unused code, behaves as a read
    localparam int         DMA_LEN    = DMA_LENGTH_DEFAULT;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              serial_valid;
        logic [DATA_W-1:0] serial_byte;
    } access_outcome_t;

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic [1:0]        kind    = KIND_READ;
    logic [ADDR_W-1:0] address = '0;
    logic [DATA_W-1:0] data    = '0;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] read_data;
    logic              serial_valid;
    logic [DATA_W-1:0] serial_byte;

    logic [DATA_W-1:0] mem_image [0:MEM_DEPTH-1];
    access_outcome_t   outcome_q [$];
    int                mismatch_count  = 0;
    int                accesses_issued = 0;
    int                gap_pct         = 0;

    io_masked_memory_with_dma dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .address      (address),
        .data         (data),
        .busy         (busy),
        .done         (done),
        .read_data    (read_data),
        .serial_valid (serial_valid),
        .serial_byte  (serial_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Memory image update for one accepted transaction; queues the byte(s) it should return.
    task automatic apply_access(input logic [1:0] k, input logic [ADDR_W-1:0] a,
                                input logic [DATA_W-1:0] d);
        access_outcome_t   res;
        logic [DATA_W-1:0] keep;
        logic [DATA_W-1:0] take;
        logic [ADDR_W-1:0] src;
        int                i;
        res = '0;
        if (k == KIND_ORDINARY || k == KIND_INIT)
        begin
            keep = 8'h00;
            take = 8'hFF;
            if (k == KIND_ORDINARY)
            begin
                case (a)
                    16'hFF00:            begin keep = 8'hCF; take = 8'h30; end
                    SERIAL_CTRL:         begin keep = 8'h7C; take = 8'h83; end
                    16'hFF07:            begin keep = 8'hF8; take = 8'h07; end
                    16'hFF0F:            begin keep = 8'hE0; take = 8'h1F; end
                    16'hFF10:            begin keep = 8'h80; take = 8'h7F; end
                    16'hFF1A:            begin keep = 8'h7F; take = 8'h80; end
                    16'hFF1C:            begin keep = 8'h9F; take = 8'h60; end
                    16'hFF21:            begin keep = 8'hC0; take = 8'h3F; end
                    16'hFF23:            begin keep = 8'h3F; take = 8'hC0; end
                    16'hFF26:            begin keep = 8'h7F; take = 8'h80; end
                    16'hFF41:            begin keep = 8'h87; take = 8'h78; end
                    16'hFFFF:            begin keep = 8'hE0; take = 8'h1F; end
                    TIMER_DIV, LCD_LINE: begin keep = 8'h00; take = 8'h00; end
                    DMA_REG:
                    begin
                        keep = 8'hFF;
                        take = 8'h00;
                        src  = {d, 8'h00};
                        // byte by byte in rising order; both addresses wrap at 16 bits
                        for (i = 0; i < DMA_LEN; i++)
                            mem_image[DMA_TARGET + ADDR_W'(i)] = mem_image[src + ADDR_W'(i)];
                    end
                    default: ;
                endcase
            end
            mem_image[a] = (mem_image[a] & keep) | (d & take);
            if (a == SERIAL_CTRL && d == SERIAL_GO)
            begin
                res.serial_valid   = 1'b1;
                res.serial_byte    = mem_image[SERIAL_DATA];
                mem_image[SERIAL_CTRL] = '0;
            end
        end
        else
        begin
            res.read_data = mem_image[a];
        end
        outcome_q.push_back(res);
    endtask

    // One transaction: optional idle gap, then hold start until busy is seen low at an edge.
    task automatic issue_access(input logic [1:0] k, input logic [ADDR_W-1:0] a,
                                input logic [DATA_W-1:0] d);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        start   <= 1'b1;
        kind    <= k;
        address <= a;
        data    <= d;
        do @(posedge clk); while (busy);
        apply_access(k, a, d);
        accesses_issued++;
    endtask

    function automatic logic [ADDR_W-1:0] io_spot(input int idx);
        case (idx)
            0:       return 16'hFF00;
            1:       return SERIAL_DATA;
            2:       return SERIAL_CTRL;
            3:       return TIMER_DIV;
            4:       return 16'hFF07;
            5:       return 16'hFF0F;
            6:       return 16'hFF10;
            7:       return 16'hFF1A;
            8:       return 16'hFF1C;
            9:       return 16'hFF21;
            10:      return 16'hFF23;
            11:      return 16'hFF26;
            12:      return 16'hFF41;
            13:      return LCD_LINE;
            14:      return DMA_REG;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Bias towards the I/O page, the sprite area and a small pool so reads see earlier writes.
    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return io_spot($urandom_range(15));
        else if (r < 45)
            return 16'hFF00 + ADDR_W'($urandom_range(127));
        else if (r < 60)
            return DMA_TARGET + ADDR_W'($urandom_range(DMA_LEN + 15));
        else if (r < 80)
            return 16'hC000 + ADDR_W'($urandom_range(31));
        return ADDR_W'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [1:0] pick_write_kind();
        return ($urandom_range(1) != 0) ? KIND_ORDINARY : KIND_INIT;
    endfunction

    function automatic logic [1:0] pick_read_kind();
        return ($urandom_range(3) == 0) ? KIND_SPARE : KIND_READ;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %02h got %02h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        access_outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (outcome_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no transaction outstanding", $time);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, read_data);
                if (serial_valid !== want.serial_valid)
                    report_mismatch("serial_valid", 8'(want.serial_valid), 8'(serial_valid));
                if (serial_byte !== want.serial_byte)
                    report_mismatch("serial_byte", want.serial_byte, serial_byte);
            end
        end
    end

    task automatic test_extremes();
        issue_access(KIND_READ,     16'h0000, 8'h00);
        issue_access(KIND_INIT,     16'hFFFF, 8'hFF);
        issue_access(KIND_SPARE,    16'hFFFF, 8'hFF);
        issue_access(KIND_ORDINARY, 16'hFFFF, 8'h00);
        issue_access(KIND_READ,     16'hFFFF, 8'h55);
        issue_access(KIND_ORDINARY, 16'h0000, 8'hFF);
        issue_access(KIND_SPARE,    16'h0000, 8'h00);
    endtask

    task automatic test_cleared_registers();
        issue_access(KIND_INIT,     TIMER_DIV, 8'hA5);
        issue_access(KIND_ORDINARY, TIMER_DIV, 8'hFF);
        issue_access(KIND_READ,     TIMER_DIV, 8'h00);
        issue_access(KIND_INIT,     LCD_LINE,  8'h5A);
        issue_access(KIND_ORDINARY, LCD_LINE,  8'hFF);
        issue_access(KIND_READ,     LCD_LINE,  8'h00);
    endtask

    // Emit on an init write too; the check looks at the data, not the masked byte.
    task automatic test_serial_output();
        issue_access(KIND_INIT,     SERIAL_DATA, 8'h3C);
        issue_access(KIND_INIT,     SERIAL_CTRL, SERIAL_GO);
        issue_access(KIND_READ,     SERIAL_CTRL, 8'h00);
        issue_access(KIND_ORDINARY, SERIAL_CTRL, SERIAL_GO);
        issue_access(KIND_ORDINARY, SERIAL_CTRL, 8'hFF);
        issue_access(KIND_READ,     SERIAL_CTRL, 8'h00);
    endtask

    task automatic test_dma_copy();
        issue_access(KIND_INIT,     16'h8000, 8'h11);
        issue_access(KIND_INIT,     16'h8000 + ADDR_W'(DMA_LEN - 1), 8'h22);
        issue_access(KIND_ORDINARY, DMA_REG, 8'h80);
        issue_access(KIND_READ,     DMA_TARGET, 8'h00);
        issue_access(KIND_READ,     DMA_TARGET + ADDR_W'(DMA_LEN - 1), 8'h00);
        issue_access(KIND_READ,     DMA_REG, 8'h00);
        issue_access(KIND_ORDINARY, DMA_REG, 8'hFF);    // source page holds the I/O registers
    endtask

    task automatic test_random(input int count, input int idle);
        int                target;
        int                r;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        logic [1:0]        k;
        gap_pct = idle;
        target  = accesses_issued + count;
        while (accesses_issued < target)
        begin
            r = $urandom_range(99);
            if (r < 50)
            begin
                a = pick_address();
                d = 8'($urandom_range(255));
                r = $urandom_range(99);
                k = (r < 35) ? KIND_READ : (r < 70) ? KIND_ORDINARY :
                    (r < 90) ? KIND_INIT : KIND_SPARE;
                if (a == SERIAL_CTRL && $urandom_range(1) != 0)
                    d = SERIAL_GO;
                // keep copies rare, they hold the block for a long time
                if (a == DMA_REG && k == KIND_ORDINARY && $urandom_range(3) != 0)
                    k = KIND_INIT;
                issue_access(k, a, d);
            end
            else if (r < 65)
            begin
                issue_access(pick_write_kind(), SERIAL_DATA, 8'($urandom_range(255)));
                d = ($urandom_range(4) != 0) ? SERIAL_GO : 8'($urandom_range(255));
                issue_access(pick_write_kind(), SERIAL_CTRL, d);
                issue_access(pick_read_kind(), ($urandom_range(1) != 0) ? SERIAL_CTRL
                                                                        : SERIAL_DATA,
                             8'($urandom_range(255)));
            end
            else if (r < 80)
            begin
                a = io_spot($urandom_range(15));
                if (a == DMA_REG)
                    a = 16'hFFFF;
                issue_access(KIND_INIT, a, 8'($urandom_range(255)));
                issue_access(KIND_ORDINARY, a, 8'($urandom_range(255)));
                issue_access(pick_read_kind(), a, 8'($urandom_range(255)));
            end
            else if (r < 90)
            begin
                d = 8'($urandom_range(255));
                issue_access(pick_write_kind(), {d, 8'h00} + ADDR_W'($urandom_range(DMA_LEN - 1)),
                             8'($urandom_range(255)));
                issue_access(KIND_ORDINARY, DMA_REG, d);
                issue_access(pick_read_kind(), DMA_TARGET + ADDR_W'($urandom_range(DMA_LEN + 7)),
                             8'($urandom_range(255)));
            end
            else
            begin
                a = ADDR_W'($urandom_range(16'hFFFF));
                issue_access(pick_write_kind(), a, 8'($urandom_range(255)));
                issue_access(pick_read_kind(), a, 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        foreach (mem_image[i])
            mem_image[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_cleared_registers();
        test_serial_output();
        test_dma_copy();
        // sender idling phases; results cannot be held off so there is no receiver side
        test_random(350, 0);
        test_random(350, 87);
        test_random(350, 0);
        test_random(350, 12);

        start <= 1'b0;
        begin : drain
            int waited;
            waited = 0;
            while (outcome_q.size() != 0 && waited < 4 * DMA_LEN + 100)
            begin
                @(posedge clk);
                waited++;
            end
        end
        repeat (DMA_LEN + 8) @(posedge clk);
        mismatch_count += outcome_q.size();

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
